[src/spr_pkg.sv]
package spr_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 24;

    localparam int LAT_W      = 24;
    localparam int LNG_W      = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_LATITUDE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_LONGITUDE = 1'd1;

    // CORDIC datapath width: Q2.30 plus headroom for the gain
    localparam int CORDIC_W = 34;

    typedef logic signed [31:0] q30_t;
    typedef logic [31:0]        bang_t;

    localparam q30_t  KQ30         = 32'sd652032874;
    localparam bang_t HALF_TURN    = 32'h8000_0000;
    localparam bang_t QUARTER_TURN = 32'h4000_0000;

    // degrees to binary angle: floor((|d| * 2^DIV_SHIFT + 22) / 45)
    localparam int          DIV_SHIFT   = 29 - ANGLE_FRAC_BITS;
    localparam int          RECIP_SHIFT = 36;
    localparam logic [30:0] RECIP45     = 31'd1527099484;
    localparam int          DIV_ROUND   = 22;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // Q2.30 rounding of a full product
    function automatic q30_t mulq_round(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd536870912;
        return 32'(t >>> 30);
    endfunction

endpackage

[src/spr_sincos.sv]
module spr_sincos (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  spr_pkg::bang_t angle,
    output logic          out_valid,
    output spr_pkg::q30_t  sin_out,
    output spr_pkg::q30_t  cos_out
);
    localparam int N = spr_pkg::CORDIC_STAGES;
    localparam int W = spr_pkg::CORDIC_W;

    logic [N+1:0]        vld_reg;
    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic                neg_reg [0:N];
    spr_pkg::q30_t       sin_reg;
    spr_pkg::q30_t       cos_reg;

    spr_pkg::bang_t shifted;
    spr_pkg::bang_t folded;

    // fold into [-90,90) and negate the results afterwards
    assign shifted = angle + spr_pkg::QUARTER_TURN;
    assign folded  = shifted[31] ? angle + spr_pkg::HALF_TURN : angle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= W'(spr_pkg::KQ30);
            y_reg[0]   <= '0;
            z_reg[0]   <= W'(signed'(folded));
            neg_reg[0] <= shifted[31];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[k][W-1]) begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - W'(spr_pkg::ATAN_TAB[k]);
                end else begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + W'(spr_pkg::ATAN_TAB[k]);
                end
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= neg_reg[N] ? 32'(-x_reg[N]) : 32'(x_reg[N]);
            sin_reg <= neg_reg[N] ? 32'(-y_reg[N]) : 32'(y_reg[N]);
        end
    end

    assign out_valid = vld_reg[N+1];
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

endmodule

[src/spr_vector.sv]
module spr_vector (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  spr_pkg::q30_t  x_in,
    input  spr_pkg::q30_t  y_in,
    output logic          out_valid,
    output spr_pkg::bang_t angle,
    output spr_pkg::q30_t  mag
);
    localparam int N = spr_pkg::CORDIC_STAGES;
    localparam int W = spr_pkg::CORDIC_W;

    logic [N+2:0]        vld_reg;
    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic                zero_reg [0:N];
    logic                off_reg [0:N];
    logic signed [W+31:0] prod_reg;
    spr_pkg::bang_t      ang_reg;
    spr_pkg::bang_t      ang_out_reg;
    spr_pkg::q30_t       mag_reg;

    logic signed [W-1:0] xe;
    logic signed [W-1:0] ye;

    assign xe = W'(x_in);
    assign ye = W'(y_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N+1:0], in_valid};
        end
    end

    // left half plane: negate and add a half turn at the end
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_in[31] ? -xe : xe;
            y_reg[0]    <= x_in[31] ? -ye : ye;
            z_reg[0]    <= '0;
            off_reg[0]  <= x_in[31];
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[k][W-1] && (y_reg[k] != '0)) begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + W'(spr_pkg::ATAN_TAB[k]);
                end else begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - W'(spr_pkg::ATAN_TAB[k]);
                end
                off_reg[k+1]  <= off_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= x_reg[N] * spr_pkg::KQ30;
            ang_reg     <= zero_reg[N] ? '0 : z_reg[N][31:0] + {off_reg[N], 31'd0};
            mag_reg     <= spr_pkg::mulq_round(prod_reg);
            ang_out_reg <= ang_reg;
        end
    end

    assign out_valid = vld_reg[N+2];
    assign angle     = ang_out_reg;
    assign mag       = mag_reg;

endmodule

[src/spherical_point_rotate.sv]
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_point_latitude, s_point_longitude
// m_        out        m_valid / m_ready   m_rotated_latitude, m_rotated_longitude
// cfg_      in         cfg_write_enable    cfg_index, cfg_write_data
//
// One point per cycle while the output is not stalled, through the degree conversion, the
// sine/cosine CORDIC, the product stages, the two chained vectoring CORDICs and the output.
// Synchronous active-low reset clears the valid bits and both rotation registers.
// The whole pipeline holds while the output register is full and not taken.
module spherical_point_rotate (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [spr_pkg::LAT_W-1:0] s_point_latitude,
    input  logic signed [spr_pkg::LNG_W-1:0] s_point_longitude,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [spr_pkg::LAT_W-1:0] m_rotated_latitude,
    output logic signed [spr_pkg::LNG_W-1:0] m_rotated_longitude,
    input  logic                             cfg_write_enable,
    input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_write_data
);
    localparam int N       = spr_pkg::CORDIC_STAGES;
    localparam int VEC_LAT = N + 3;
    localparam int F       = spr_pkg::ANGLE_FRAC_BITS;
    localparam int LANES   = 4;
    localparam logic signed [25:0] LAT_LIM = 26'sd90 <<< F;

    logic en;

    logic signed [spr_pkg::LAT_W-1:0] rot_lat_reg;
    logic signed [spr_pkg::LNG_W-1:0] rot_lng_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_lat_reg <= '0;
            rot_lng_reg <= '0;
        end else if (cfg_write_enable) begin
            unique case (cfg_index)
                spr_pkg::REG_ROTATION_LATITUDE:  rot_lat_reg <= cfg_write_data[spr_pkg::LAT_W-1:0];
                spr_pkg::REG_ROTATION_LONGITUDE: rot_lng_reg <= cfg_write_data[spr_pkg::LNG_W-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless the output holds a request not taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // degrees to binary angle, four lanes: point lat, point lng, rot lat, rot lng
    logic signed [24:0] lane_in [LANES];
    assign lane_in[0] = 25'(s_point_latitude);
    assign lane_in[1] = s_point_longitude;
    assign lane_in[2] = 25'(rot_lat_reg);
    assign lane_in[3] = rot_lng_reg;

    logic [3:0]         cv_reg;
    logic               neg1_reg [LANES];
    logic [24:0]        m1_reg [LANES];
    logic [55:0]        p1_reg [LANES];
    logic               neg2_reg [LANES];
    logic [19:0]        a2_reg [LANES];
    logic [31:0]        v2_reg [LANES];
    logic               neg3_reg [LANES];
    logic [19:0]        a3_reg [LANES];
    logic [62:0]        p3_reg [LANES];
    spr_pkg::bang_t     bin_reg [LANES];
    spr_pkg::q30_t      sin_w [LANES];
    spr_pkg::q30_t      cos_w [LANES];
    logic               sc_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= '0;
        end else if (en) begin
            cv_reg <= {cv_reg[2:0], s_valid};
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [25:0] r_full;
        logic [63:0] q_full;
        assign r_full = 26'(m1_reg[l]) - 26'(p1_reg[l][55:spr_pkg::RECIP_SHIFT]) * 26'd45;
        assign q_full = (64'(a3_reg[l]) << spr_pkg::DIV_SHIFT)
                      + 64'(p3_reg[l][62:spr_pkg::RECIP_SHIFT]);

        always_ff @(posedge aclk) begin
            if (en) begin
                neg1_reg[l] <= lane_in[l][24];
                m1_reg[l]   <= lane_in[l][24] ? 25'(-lane_in[l]) : 25'(lane_in[l]);
                p1_reg[l]   <= 56'($unsigned(lane_in[l][24] ? -lane_in[l] : lane_in[l]))
                             * 56'(spr_pkg::RECIP45);
                neg2_reg[l] <= neg1_reg[l];
                a2_reg[l]   <= p1_reg[l][spr_pkg::RECIP_SHIFT+19:spr_pkg::RECIP_SHIFT];
                v2_reg[l]   <= (32'(r_full[5:0]) << spr_pkg::DIV_SHIFT)
                             + 32'(spr_pkg::DIV_ROUND);
                neg3_reg[l] <= neg2_reg[l];
                a3_reg[l]   <= a2_reg[l];
                p3_reg[l]   <= 63'(v2_reg[l]) * 63'(spr_pkg::RECIP45);
                bin_reg[l]  <= neg3_reg[l] ? 32'(-q_full) : q_full[31:0];
            end
        end

        if (l == 0) begin : g_lead
            spr_sincos u_sincos (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .in_valid (cv_reg[3]),
                .angle    (bin_reg[l]),
                .out_valid(sc_valid),
                .sin_out  (sin_w[l]),
                .cos_out  (cos_w[l])
            );
        end else begin : g_side
            spr_sincos u_sincos (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .in_valid (cv_reg[3]),
                .angle    (bin_reg[l]),
                .out_valid(),
                .sin_out  (sin_w[l]),
                .cos_out  (cos_w[l])
            );
        end
    end

    // unit vector and rotation: product stages alternate with round and sum stages
    logic [5:0]          pv_reg;
    logic signed [65:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    spr_pkg::q30_t       z1_reg, sz1_reg, cz1_reg, sy1_reg, cy1_reg;
    spr_pkg::q30_t       x2_reg, y2_reg, z2_reg, sz2_reg, cz2_reg, sy2_reg, cy2_reg;
    spr_pkg::q30_t       z3_reg, sy3_reg, cy3_reg;
    spr_pkg::q30_t       u4_reg, ny4_reg, z4_reg, sy4_reg, cy4_reg;
    spr_pkg::q30_t       ny5_reg;
    spr_pkg::q30_t       nx6_reg, ny6_reg, nz6_reg;
    logic signed [65:0]  pe_reg, pf_reg;
    logic signed [65:0]  pa2_reg, pb2_reg, pc2_reg, pd2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (en) begin
            pv_reg <= {pv_reg[4:0], sc_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg  <= 66'(cos_w[0]) * 66'(cos_w[1]);
            pb_reg  <= 66'(cos_w[0]) * 66'(sin_w[1]);
            z1_reg  <= sin_w[0];
            sy1_reg <= sin_w[2];
            cy1_reg <= cos_w[2];
            sz1_reg <= sin_w[3];
            cz1_reg <= cos_w[3];

            x2_reg  <= -spr_pkg::mulq_round(pa_reg);
            y2_reg  <= spr_pkg::mulq_round(pb_reg);
            z2_reg  <= z1_reg;
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;
            sz2_reg <= sz1_reg;
            cz2_reg <= cz1_reg;

            pc_reg  <= 66'(cz2_reg) * 66'(x2_reg);
            pd_reg  <= 66'(sz2_reg) * 66'(y2_reg);
            z3_reg  <= z2_reg;
            sy3_reg <= sy2_reg;
            cy3_reg <= cy2_reg;

            u4_reg  <= spr_pkg::mulq_round(pc_reg) - spr_pkg::mulq_round(pd_reg);
            z4_reg  <= z3_reg;
            sy4_reg <= sy3_reg;
            cy4_reg <= cy3_reg;

            ny5_reg <= ny4_reg;
            nx6_reg <= spr_pkg::mulq_round(pa2_reg) - spr_pkg::mulq_round(pb2_reg);
            nz6_reg <= spr_pkg::mulq_round(pc2_reg) + spr_pkg::mulq_round(pd2_reg);
            ny6_reg <= ny5_reg;
        end
    end

    // second products of the first rotation and the products of the second
    always_ff @(posedge aclk) begin
        if (en) begin
            pe_reg  <= 66'(sz2_reg) * 66'(x2_reg);
            pf_reg  <= 66'(cz2_reg) * 66'(y2_reg);
            ny4_reg <= spr_pkg::mulq_round(pe_reg) + spr_pkg::mulq_round(pf_reg);
            pa2_reg <= 66'(cy4_reg) * 66'(u4_reg);
            pb2_reg <= 66'(sy4_reg) * 66'(z4_reg);
            pc2_reg <= 66'(cy4_reg) * 66'(z4_reg);
            pd2_reg <= 66'(sy4_reg) * 66'(u4_reg);
        end
    end

    // longitude and horizontal magnitude, then latitude
    logic           v1_valid, v2_valid;
    spr_pkg::bang_t lng_ang, lat_ang;
    spr_pkg::q30_t  mag_w;
    spr_pkg::q30_t  nz_dly_reg [0:VEC_LAT-1];
    spr_pkg::bang_t lng_dly_reg [0:VEC_LAT-1];

    spr_vector u_vec_lng (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (pv_reg[5]),
        .x_in     (nx6_reg),
        .y_in     (ny6_reg),
        .out_valid(v1_valid),
        .angle    (lng_ang),
        .mag      (mag_w)
    );

    spr_vector u_vec_lat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v1_valid),
        .x_in     (mag_w),
        .y_in     (nz_dly_reg[VEC_LAT-1]),
        .out_valid(v2_valid),
        .angle    (lat_ang),
        .mag      ()
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            nz_dly_reg[0]  <= nz6_reg;
            lng_dly_reg[0] <= lng_ang;
            for (int k = 1; k < VEC_LAT; k++) begin
                nz_dly_reg[k]  <= nz_dly_reg[k-1];
                lng_dly_reg[k] <= lng_dly_reg[k-1];
            end
        end
    end

    // back to degrees, then clamp latitude
    logic [1:0]         fv_reg;
    logic signed [41:0] lat_t, lng_t;
    logic signed [25:0] lat_deg_reg;
    logic signed [25:0] lng_deg_reg;
    logic signed [spr_pkg::LAT_W-1:0] lat_out_reg;
    logic signed [spr_pkg::LNG_W-1:0] lng_out_reg;

    assign lat_t = 42'(signed'(lat_ang)) * 42'sd360 + (42'sd1 <<< (31 - F));
    assign lng_t = 42'(signed'(lng_dly_reg[VEC_LAT-1])) * 42'sd360 + (42'sd1 <<< (31 - F));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[0], v2_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lat_deg_reg <= 26'(lat_t >>> (32 - F));
            lng_deg_reg <= 26'(lng_t >>> (32 - F));
            if (lat_deg_reg > LAT_LIM) begin
                lat_out_reg <= spr_pkg::LAT_W'(LAT_LIM);
            end else if (lat_deg_reg < -LAT_LIM) begin
                lat_out_reg <= spr_pkg::LAT_W'(-LAT_LIM);
            end else begin
                lat_out_reg <= lat_deg_reg[spr_pkg::LAT_W-1:0];
            end
            lng_out_reg <= lng_deg_reg[spr_pkg::LNG_W-1:0];
        end
    end

    assign m_valid             = fv_reg[1];
    assign m_rotated_latitude  = lat_out_reg;
    assign m_rotated_longitude = lng_out_reg;

endmodule
